FILE: sv/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, codes and constants of the peer liveness table
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [7:0]  RESPONSE_CHANCES_RST = 8'd1;
  localparam logic [15:0] DISCOVERY_PORT_RST   = 16'd28181;

  typedef enum logic [1:0] {
    FN_HEARD   = 2'd0,
    FN_GOODBYE = 2'd1,
    FN_TICK    = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EV_FOUND   = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_GOODBYE = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  typedef enum logic {
    CFG_RESPONSE_CHANCES = 1'b0,
    CFG_DISCOVERY_PORT   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [47:0] peer_endpoint;
    logic [31:0] discovery_ip;
  } in_word_t;

  typedef struct packed {
    event_t      event_res;
    logic [3:0]  slot;
    logic [47:0] peer_address;
    logic [47:0] discovery_endpoint;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] endpoint;
    logic [31:0] disc_ip;
    logic [8:0]  chances;
  } entry_t;

  typedef struct packed {
    func_t op;
    logic  insert;
  } head_ctrl_t;

  typedef struct packed {
    logic   emit;
    event_t ev;
    logic   match;
    logic   free;
  } head_stat_t;

  function automatic logic [47:0] make_disc(input logic [31:0] ip, input logic [15:0] port);
    return {ip, port};
  endfunction

endpackage

FILE: sv/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell
// one table entry of the ring, handed to its neighbour on every shift
// ----------------------------------------------------------------------------
module plt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  plt_pkg::entry_t d,
  output plt_pkg::entry_t q
);
  import plt_pkg::*;

  logic        valid;
  logic [47:0] endpoint;
  logic [31:0] disc_ip;
  logic [8:0]  chances;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      endpoint <= d.endpoint;
      disc_ip  <= d.disc_ip;
      chances  <= d.chances;
    end
  end

  assign q = '{valid: valid, endpoint: endpoint, disc_ip: disc_ip, chances: chances};

endmodule

FILE: sv/plt_head.sv
// ----------------------------------------------------------------------------
// plt_head
// update logic at the ring head: refresh, remove, age and insert
// ----------------------------------------------------------------------------
module plt_head #(
  parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
  input  plt_pkg::head_ctrl_t              ctrl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   idx,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   ins_idx,
  input  plt_pkg::entry_t                  cur,
  input  logic [47:0]                      ep,
  input  logic [31:0]                      ip,
  input  logic [8:0]                       refill,
  output plt_pkg::entry_t                  entry_next,
  output plt_pkg::head_stat_t              stat
);
  import plt_pkg::*;

  logic match;

  assign match = cur.valid && (cur.endpoint == ep);

  always_comb begin
    entry_next = cur;
    stat       = '{emit: 1'b0, ev: EV_FOUND, match: 1'b0, free: 1'b0};
    if (ctrl.insert) begin
      if (idx == ins_idx) begin
        entry_next = '{valid: 1'b1, endpoint: ep, disc_ip: ip, chances: refill};
      end
    end else begin
      case (ctrl.op)
        FN_HEARD: begin
          stat.free = !cur.valid;
          if (match) begin
            stat.match         = 1'b1;
            entry_next.chances = refill;
          end
        end
        FN_GOODBYE: begin
          if (match) begin
            entry_next.valid = 1'b0;
            stat.emit        = 1'b1;
            stat.ev          = EV_GOODBYE;
          end
        end
        FN_TICK: begin
          if (cur.valid) begin
            if (cur.chances == 9'd0) begin
              entry_next.valid = 1'b0;
              stat.emit        = 1'b1;
              stat.ev          = EV_TIMEOUT;
            end else begin
              entry_next.chances = cur.chances - 9'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/peer_liveness_table.sv
// ----------------------------------------------------------------------------
// peer_liveness_table
// heartbeat membership table with per-peer miss counters
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH entry cells. Each accepted word with a
// used function code rotates the ring once, one slot per cycle while no result
// is held up, through an update unit at the head, so slots are visited in
// ascending order and every entry is back in place after a full rotation. A
// goodbye, a tick, a heard-alive for a known peer or a heard-alive into a full
// table takes one rotation and a flush of the holding register before the next
// acceptance; a heard-alive for a new peer with a free slot needs a second
// rotation to write the lowest free slot. A word with the unused function code
// is dropped, and the next word can be accepted in the following cycle. The
// rotation pauses while a result cannot move because the result channel stalls.
// Result words for one input pass through a one-word holding register so that
// the last one can be marked; the result channel has its own output register.
module peer_liveness_table #(
  parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  plt_pkg::in_word_t    req_word,
  output logic                 res_valid,
  input  logic                 res_stall,
  output plt_pkg::out_word_t   res_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  plt_pkg::cfg_index_t  cfg_index,
  input  logic [15:0]          cfg_data
);
  import plt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  state_t state, state_next;

  logic [7:0]  response_chances;
  logic [15:0] discovery_port;

  func_t       op;
  logic [47:0] cmd_ep;
  logic [31:0] cmd_ip;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] free_idx;
  logic             match_found;
  logic             free_found;

  logic      pend_valid;
  out_word_t pend;

  entry_t     ring_q [TABLE_DEPTH];
  entry_t     head_next;
  head_stat_t hs;
  head_ctrl_t hctrl;

  logic       accept;
  logic       out_free;
  logic       last_step;
  logic       step_ok;
  logic       match_now;
  logic       free_now;
  logic [IDX_W-1:0] free_idx_now;
  logic [8:0] refill;

  logic       ring_shift;
  logic       push;
  out_word_t  push_word;
  logic       pend_load;
  logic       pend_clear;
  out_word_t  pend_new;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;
  assign last_step = (idx == IDX_W'(TABLE_DEPTH - 1));
  assign refill    = {1'b0, response_chances} + 9'd1;

  assign match_now    = match_found || hs.match;
  assign free_now     = free_found || hs.free;
  assign free_idx_now = free_found ? free_idx : idx;

  assign hctrl = '{op: op, insert: (state == ST_INSERT)};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      response_chances <= RESPONSE_CHANCES_RST;
      discovery_port   <= DISCOVERY_PORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESPONSE_CHANCES: response_chances <= cfg_data[7:0];
        CFG_DISCOVERY_PORT:   discovery_port   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ring of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t d;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign d = head_next;
    end else begin : g_mid
      assign d = ring_q[i+1];
    end
    plt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring_shift),
      .d     (d),
      .q     (ring_q[i])
    );
  end

  plt_head #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_head (
    .ctrl       (hctrl),
    .idx        (idx),
    .ins_idx    (free_idx),
    .cur        (ring_q[0]),
    .ep         (cmd_ep),
    .ip         (cmd_ip),
    .refill     (refill),
    .entry_next (head_next),
    .stat       (hs)
  );

  assign step_ok = !(hs.emit && pend_valid && !out_free);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (req_word.func != FN_NONE)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_ok && last_step) begin
          if ((op == FN_HEARD) && !match_now && free_now) begin
            state_next = ST_INSERT;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_INSERT: begin
        if (last_step) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ring_shift = 1'b0;
    push       = 1'b0;
    push_word  = pend;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    pend_new   = '{event_res: hs.ev, slot: 4'(idx), peer_address: ring_q[0].endpoint,
                   discovery_endpoint: make_disc(ring_q[0].disc_ip, discovery_port),
                   last: 1'b0};
    case (state)
      ST_SCAN: begin
        ring_shift = step_ok;
        if (step_ok && hs.emit) begin
          push           = pend_valid;
          push_word.last = 1'b0;
          pend_load      = 1'b1;
        end
        if (step_ok && last_step && (op == FN_HEARD) && !match_now && !free_now) begin
          pend_load = 1'b1;
          pend_new  = '{event_res: EV_REJECT, slot: 4'd0, peer_address: cmd_ep,
                        discovery_endpoint: make_disc(cmd_ip, discovery_port),
                        last: 1'b0};
        end
      end
      ST_INSERT: begin
        ring_shift = 1'b1;
        if (last_step) begin
          pend_load = 1'b1;
          pend_new  = '{event_res: EV_FOUND, slot: 4'(free_idx), peer_address: cmd_ep,
                        discovery_endpoint: make_disc(cmd_ip, discovery_port),
                        last: 1'b0};
        end
      end
      ST_FLUSH: begin
        if (pend_valid && out_free) begin
          push           = 1'b1;
          push_word.last = 1'b1;
          pend_clear     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command word
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req_word.func;
      cmd_ep <= req_word.peer_endpoint;
      cmd_ip <= req_word.discovery_ip;
    end
  end

  // slot counter and search flags
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      free_idx    <= '0;
    end else if (accept) begin
      idx         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (ring_shift) begin
      idx <= last_step ? '0 : idx + IDX_W'(1);
      if (state == ST_SCAN) begin
        match_found <= match_now;
        free_found  <= free_now;
        free_idx    <= free_idx_now;
      end
    end
  end

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_load) begin
      pend_valid <= 1'b1;
    end else if (pend_clear) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend <= pend_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_word <= push_word;
    end
  end

endmodule
